/* rtl/core/trfv_pkg.sv */
`timescale 1ns / 1ps

package trfv_pkg;

  // code width and tick width
  localparam int unsigned ValueW   = 32;
  localparam int unsigned IncW     = 20;

  // set path: one quotient bit per cycle over the whole magnitude
  localparam int unsigned DivSteps = ValueW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  // add/subtract path: one increment bit per cycle
  localparam int unsigned MulSteps = IncW;
  localparam int unsigned MulCntW  = $clog2(MulSteps + 1);

  // accumulator holds stored code plus ticks times increment without loss
  localparam int unsigned AccW     = ValueW + IncW + 2;

  // set path works two bits wider than the code to see range overflow
  localparam int unsigned ExtW     = ValueW + 2;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_CMP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RND_NEAREST_EVEN = 2'd0,
    RND_CEIL         = 2'd1,
    RND_FLOOR        = 2'd2,
    RND_EXACT        = 2'd3
  } rnd_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_INEXACT  = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    CMP_LESS    = 2'd0,
    CMP_EQUAL   = 2'd1,
    CMP_GREATER = 2'd2
  } cmp_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX1,
    ST_FIX2,
    ST_FIX3,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic done;   // one-cycle pulse, remainder valid from here on
    logic q_lsb;  // lowest quotient bit of the magnitude division
  } div_stat_t;

endpackage

/* rtl/core/trfv_div.sv */
`timescale 1ns / 1ps

module trfv_div import trfv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] dividend_i,
  input  logic [IncW-1:0]   divisor_i,
  output div_stat_t         stat_o,
  output logic [IncW-1:0]   rem_o
);

  logic [ValueW-1:0]  dvd_q, dvd_d;
  logic [IncW-1:0]    dsr_q, dsr_d;
  logic [IncW-1:0]    rem_q, rem_d;
  logic               qbit_q, qbit_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [IncW:0]      trial;
  logic               ge;

  // restoring radix-2 step: bring down one dividend bit per cycle
  always_comb begin
    trial  = {rem_q, dvd_q[ValueW-1]};
    ge     = (trial >= {1'b0, dsr_q});
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    qbit_d = qbit_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      dsr_d = divisor_i;
      rem_d = '0;
      cnt_d = DivCntW'(DivSteps);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? IncW'(trial - {1'b0, dsr_q}) : trial[IncW-1:0];
      qbit_d = ge;
      dvd_d  = {dvd_q[ValueW-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
    rem_q  <= rem_d;
    qbit_q <= qbit_d;
  end

  assign stat_o.done  = done_q;
  assign stat_o.q_lsb = qbit_q;
  assign rem_o        = rem_q;

endmodule

/* rtl/core/trfv_mul.sv */
`timescale 1ns / 1ps

module trfv_mul import trfv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AccW-1:0]   acc_init_i,
  input  logic [AccW-1:0]   addend_i,
  input  logic [IncW-1:0]   mult_i,
  output logic              done_o,
  output logic [AccW-1:0]   acc_o
);

  logic [AccW-1:0]    acc_q, acc_d;
  logic [AccW-1:0]    add_q, add_d;
  logic [IncW-1:0]    mlt_q, mlt_d;
  logic [MulCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;

  // shift-and-add, one multiplier bit per cycle, lsb first
  always_comb begin
    acc_d  = acc_q;
    add_d  = add_q;
    mlt_d  = mlt_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = acc_init_i;
      add_d = addend_i;
      mlt_d = mult_i;
      cnt_d = MulCntW'(MulSteps);
    end else if (cnt_q != '0) begin
      if (mlt_q[0]) begin
        acc_d = acc_q + add_q;
      end
      add_d  = {add_q[AccW-2:0], 1'b0};
      mlt_d  = {1'b0, mlt_q[IncW-1:1]};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == MulCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    add_q <= add_d;
    mlt_q <= mlt_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

/* rtl/core/tick_rounding_fixed_value.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// in        to block   in_valid_i / in_stall_o      opcode, value_in, round_mode,
//                                                   tick_count, other_code
// out       from block out_valid_o / out_stall_i    code_out, error_code, compare_result
// cfg       to block   cfg_we_i                     cfg_data_i (increment)
//
// set runs the divider over the magnitude (one quotient bit a cycle), waits in ST_DIV
// for it to finish, takes three rounding steps (ST_FIX1 to ST_FIX3), loads the output
// in ST_DONE and returns to ST_IDLE to take the next item. add and subtract run the
// shift-and-add over the increment bits, then ST_DONE; compare goes straight to ST_DONE.
// one transaction in flight; its result sits in an output register, so the next item
// is taken while that result waits on out_stall_i, and the one after waits for it.
// reset clears the stored code to zero and the increment to one.

module tick_rounding_fixed_value import trfv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic signed [ValueW-1:0] value_in_i,
  input  logic [1:0]               round_mode_i,
  input  logic signed [ValueW-1:0] tick_count_i,
  input  logic signed [ValueW-1:0] other_code_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ValueW-1:0] code_out_o,
  output logic [1:0]               error_code_o,
  output logic [1:0]               compare_result_o,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [IncW-1:0]          cfg_data_i
);

  state_e state_q, state_d;

  // architectural state
  logic [IncW-1:0]   inc_q;
  logic [ValueW-1:0] stored_q, stored_d;

  // captured item
  op_e               op_q;
  rnd_e              mode_q;
  logic [ExtW-1:0]   v_q;
  logic              neg_q;

  // rounding pipeline
  logic [IncW-1:0]   r_q, r_d;
  logic              qodd_q, qodd_d;
  logic [ExtW-1:0]   base_q, base_d;
  logic              up_q, up_d;
  logic              inexact_q, inexact_d;

  // pending result
  logic [ValueW-1:0] res_code_q, res_code_d;
  err_e              res_err_q, res_err_d;
  cmp_e              res_cmp_q, res_cmp_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_code_q, out_code_d;
  err_e              out_err_q, out_err_d;
  cmp_e              out_cmp_q, out_cmp_d;

  logic              accept;
  logic              out_free;
  op_e               op_in;
  logic [IncW-1:0]   inc_eff;
  logic [ValueW-1:0] v_u;
  logic [ValueW-1:0] mag;

  // serial units
  logic              div_start;
  div_stat_t         div_stat;
  logic [IncW-1:0]   div_rem;
  logic              mul_start;
  logic              mul_done;
  logic [AccW-1:0]   mul_acc;
  logic [AccW-1:0]   acc_init;
  logic [AccW-1:0]   tk_sx;
  logic [AccW-1:0]   addend;

  // fix-up helpers
  logic              rem_nz;
  logic              r_nz;
  logic [IncW:0]     r_twice;
  logic [IncW:0]     inc_wide;
  logic [ExtW-1:0]   rounded;
  logic              rounded_fits;
  logic              acc_fits;

  assign op_in    = op_e'(opcode_i);
  assign inc_eff  = (inc_q == '0) ? IncW'(1) : inc_q;   // zero increment acts as one
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // set path divides the magnitude, sign handled after
  assign v_u       = value_in_i;
  assign mag       = v_u[ValueW-1] ? (~v_u + 1'b1) : v_u;
  assign div_start = accept && (op_in == OP_SET);

  // add/subtract: accumulator starts at the stored code, adds +/- ticks per set bit
  assign acc_init  = {{(AccW-ValueW){stored_q[ValueW-1]}}, stored_q};
  assign tk_sx     = {{(AccW-ValueW){tick_count_i[ValueW-1]}}, tick_count_i};
  assign addend    = (op_in == OP_SUB) ? (~tk_sx + 1'b1) : tk_sx;
  assign mul_start = accept && ((op_in == OP_ADD) || (op_in == OP_SUB));

  trfv_div u_trfv_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (inc_eff),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  trfv_mul u_trfv_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mul_start),
    .acc_init_i (acc_init),
    .addend_i   (addend),
    .mult_i     (inc_eff),
    .done_o     (mul_done),
    .acc_o      (mul_acc)
  );

  // floor remainder and quotient parity from the truncated division
  assign rem_nz   = (div_rem != '0);
  // rounding decision on the floor remainder
  assign r_nz     = (r_q != '0);
  assign r_twice  = {r_q, 1'b0};
  assign inc_wide = {1'b0, inc_eff};
  // final multiple and its range check
  assign rounded      = base_q + (up_q ? ExtW'(inc_eff) : ExtW'(0));
  assign rounded_fits = (rounded[ExtW-1:ValueW-1] == {(ExtW-ValueW+1){rounded[ValueW-1]}});
  assign acc_fits     = (mul_acc[AccW-1:ValueW-1] == {(AccW-ValueW+1){mul_acc[ValueW-1]}});

  always_comb begin
    state_d     = state_q;
    stored_d    = stored_q;
    r_d         = r_q;
    qodd_d      = qodd_q;
    base_d      = base_q;
    up_d        = up_q;
    inexact_d   = inexact_q;
    res_code_d  = res_code_q;
    res_err_d   = res_err_q;
    res_cmp_d   = res_cmp_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_code_d  = out_code_q;
    out_err_d   = out_err_q;
    out_cmp_d   = out_cmp_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_SET: state_d = ST_DIV;
            OP_ADD, OP_SUB: state_d = ST_MUL;
            default: begin
              // compare needs nothing serial, result ready at once
              res_code_d = stored_q;
              res_err_d  = ERR_NONE;
              if ($signed(stored_q) < other_code_i) begin
                res_cmp_d = CMP_LESS;
              end else if ($signed(stored_q) > other_code_i) begin
                res_cmp_d = CMP_GREATER;
              end else begin
                res_cmp_d = CMP_EQUAL;
              end
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_FIX1;
        end
      end
      ST_FIX1: begin
        // negative dividend with a remainder: floor quotient is one lower
        r_d     = (neg_q && rem_nz) ? (inc_eff - div_rem) : div_rem;
        qodd_d  = div_stat.q_lsb ^ (neg_q && rem_nz);
        state_d = ST_FIX2;
      end
      ST_FIX2: begin
        base_d    = v_q - ExtW'(r_q);
        up_d      = 1'b0;
        inexact_d = 1'b0;
        case (mode_q)
          RND_NEAREST_EVEN: up_d = (r_twice > inc_wide) || ((r_twice == inc_wide) && qodd_q);
          RND_CEIL:         up_d = r_nz;
          RND_FLOOR:        up_d = 1'b0;
          default: begin
            // exact only: a miss keeps the multiple truncated toward zero
            inexact_d = r_nz;
            up_d      = neg_q && r_nz;
          end
        endcase
        state_d = ST_FIX3;
      end
      ST_FIX3: begin
        res_code_d = rounded[ValueW-1:0];
        res_cmp_d  = CMP_EQUAL;
        if (inexact_q) begin
          res_err_d = ERR_INEXACT;
        end else if (!rounded_fits) begin
          res_err_d = ERR_OVERFLOW;
        end else begin
          res_err_d = ERR_NONE;
        end
        state_d = ST_DONE;
      end
      ST_MUL: begin
        if (mul_done) begin
          res_code_d = mul_acc[ValueW-1:0];
          res_err_d  = acc_fits ? ERR_NONE : ERR_OVERFLOW;
          res_cmp_d  = CMP_EQUAL;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand over once the output register is empty or being drained
        if (out_free) begin
          out_valid_d = 1'b1;
          out_code_d  = res_code_q;
          out_err_d   = res_err_q;
          out_cmp_d   = res_cmp_q;
          stored_d    = res_code_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inc_q       <= IncW'(1);
      stored_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stored_q    <= stored_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        inc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_in;
      mode_q <= rnd_e'(round_mode_i);
      v_q    <= {{(ExtW-ValueW){v_u[ValueW-1]}}, v_u};
      neg_q  <= v_u[ValueW-1];
    end
    r_q        <= r_d;
    qodd_q     <= qodd_d;
    base_q     <= base_d;
    up_q       <= up_d;
    inexact_q  <= inexact_d;
    res_code_q <= res_code_d;
    res_err_q  <= res_err_d;
    res_cmp_q  <= res_cmp_d;
    out_code_q <= out_code_d;
    out_err_q  <= out_err_d;
    out_cmp_q  <= out_cmp_d;
  end

  assign out_valid_o      = out_valid_q;
  assign code_out_o       = out_code_q;
  assign error_code_o     = out_err_q;
  assign compare_result_o = (op_q == OP_CMP) || (out_cmp_q != CMP_EQUAL) ? out_cmp_q : CMP_EQUAL;

endmodule

/* rtl/core/trfv_checker.sv */
`timescale 1ns / 1ps

module trfv_checker import trfv_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [1:0]        opcode_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ValueW-1:0] code_out_o,
  input logic [1:0]        error_code_o,
  input logic [1:0]        compare_result_o
);

  // one transaction in flight: an accept always closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a transaction is in flight");

  // an ordering result (less or greater) never carries an error code
  a_cmp_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (compare_result_o != CMP_EQUAL)) |-> (error_code_o == ERR_NONE))
    else $error("ordering result carries an error code");

  // compare into an empty output register goes from ST_DONE straight into it
  a_cmp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (opcode_i == OP_CMP) && !out_valid_o) |-> ##2 out_valid_o)
    else $error("compare result late");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(code_out_o) && $stable(error_code_o) && $stable(compare_result_o)))
    else $error("stalled output changed");

endmodule

bind tick_rounding_fixed_value trfv_checker u_trfv_checker (.*);

/* sim/tick_value_checker.sv */
`timescale 1ns / 1ps

module tick_value_checker import trfv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               opcode_i,
  input  logic signed [ValueW-1:0] value_in_i,
  input  logic [1:0]               round_mode_i,
  input  logic signed [ValueW-1:0] tick_count_i,
  input  logic signed [ValueW-1:0] other_code_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [ValueW-1:0] code_out_i,
  input  logic [1:0]               error_code_i,
  input  logic [1:0]               compare_result_i,
  input  logic                     cfg_we_i,
  input  logic [IncW-1:0]          cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic signed [ValueW-1:0] code;
    err_e                     err;
    cmp_e                     cmp;
  } tick_result_t;

  tick_result_t    awaited_q[$];
  logic [IncW-1:0] tick_size = 1;
  longint          held_code = 0;
  int              fails = 0;

  // low ValueW bits, sign extended back
  function automatic longint wrap_code(input longint x);
    return longint'($signed(x[ValueW-1:0]));
  endfunction

  // applies one transaction to the held code and returns the result it must give
  function automatic tick_result_t step_tick_value(input op_e op,
                                                   input logic signed [ValueW-1:0] value,
                                                   input rnd_e mode,
                                                   input logic signed [ValueW-1:0] ticks,
                                                   input logic signed [ValueW-1:0] other);
    tick_result_t res;
    longint       inc;
    longint       num;
    longint       q;
    longint       r;
    longint       total;
    res.err = ERR_NONE;
    res.cmp = CMP_EQUAL;
    inc = (tick_size == '0) ? longint'(1) : longint'(tick_size);
    case (op)
      OP_SET: begin
        num = longint'(value);
        q = num / inc;
        r = num - q * inc;
        // floor quotient, remainder in [0, inc)
        if (r < 0) begin
          q = q - 1;
          r = r + inc;
        end
        case (mode)
          RND_NEAREST_EVEN: begin
            if (2 * r > inc || (2 * r == inc && q[0])) q = q + 1;
          end
          RND_CEIL: begin
            if (r != 0) q = q + 1;
          end
          RND_FLOOR: ;
          default: begin
            if (r != 0) begin
              res.err = ERR_INEXACT;
              if (num < 0) q = q + 1;
            end
          end
        endcase
        total = q * inc;
        if (wrap_code(total) != total && res.err == ERR_NONE) res.err = ERR_OVERFLOW;
        held_code = wrap_code(total);
      end
      OP_ADD, OP_SUB: begin
        total = longint'(ticks) * inc;
        if (op == OP_SUB) total = -total;
        total = held_code + total;
        if (wrap_code(total) != total) res.err = ERR_OVERFLOW;
        held_code = wrap_code(total);
      end
      default: begin
        if (held_code < longint'(other)) res.cmp = CMP_LESS;
        else if (held_code > longint'(other)) res.cmp = CMP_GREATER;
      end
    endcase
    res.code = held_code[ValueW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tick_result_t got;
    tick_result_t want;
    if (!rst_ni) begin
      tick_size = 1;
      held_code = 0;
      awaited_q.delete();
      pending_o <= 0;
      fail_count_o <= fails;
    end else begin
      if (cfg_we_i) tick_size = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        got = '{code_out_i, err_e'(error_code_i), cmp_e'(compare_result_i)};
        if (awaited_q.size() == 0) begin
          $display("%0t: result with nothing awaited: code_out %0d error_code %0d compare %0d",
                   $time, got.code, got.err, got.cmp);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          if (got.code !== want.code) begin
            $display("%0t: code_out expected %0d got %0d", $time, want.code, got.code);
            fails++;
          end
          if (got.err !== want.err) begin
            $display("%0t: error_code expected %0d got %0d", $time, want.err, got.err);
            fails++;
          end
          if (got.cmp !== want.cmp) begin
            $display("%0t: compare_result expected %0d got %0d", $time, want.cmp, got.cmp);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_q.push_back(step_tick_value(op_e'(opcode_i), value_in_i, rnd_e'(round_mode_i),
                                            tick_count_i, other_code_i));
      end
      pending_o <= awaited_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

/* sim/tb_tick_rounding_fixed_value.sv */
`timescale 1ns / 1ps

module tb_tick_rounding_fixed_value;
  import trfv_pkg::*;

  localparam int unsigned PhaseCount   = 12;
  localparam int unsigned PhaseItems   = 156;
  // hard limit many times over what a slow run takes
  localparam int          CycleLimit   = 1_000_000;
  // set is the longest operation
  localparam int unsigned SettleCycles = 40;

  localparam logic [ValueW-1:0] CodeMax = 32'h7fff_ffff;
  localparam logic [ValueW-1:0] CodeMin = 32'h8000_0000;

  // every input starts at a known value
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  op_e               opcode = OP_CMP;
  logic [ValueW-1:0] value_in = '0;
  rnd_e              round_mode = RND_NEAREST_EVEN;
  logic [ValueW-1:0] tick_count = '0;
  logic [ValueW-1:0] other_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ValueW-1:0] code_out;
  logic [1:0]        error_code;
  logic [1:0]        compare_result;
  logic              cfg_we = 1'b0;
  logic [IncW-1:0]   cfg_data = '0;

  int                send_gap_pct = 0;
  int                stall_pct = 0;
  int                cycle_count = 0;
  int                fail_count;
  int                pending;
  // tick size as the block uses it: zero behaves as one
  longint            eff_tick = 1;
  logic [IncW-1:0]   tick_plan [PhaseCount];

  always #10 clk = ~clk;

  tick_rounding_fixed_value dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .value_in_i       (value_in),
    .round_mode_i     (round_mode),
    .tick_count_i     (tick_count),
    .other_code_i     (other_code),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .code_out_o       (code_out),
    .error_code_o     (error_code),
    .compare_result_o (compare_result),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data)
  );

  // watches both channels and the config port, predicts and compares
  tick_value_checker value_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .opcode_i         (opcode),
    .value_in_i       (value_in),
    .round_mode_i     (round_mode),
    .tick_count_i     (tick_count),
    .other_code_i     (other_code),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .code_out_i       (code_out),
    .error_code_i     (error_code),
    .compare_result_i (compare_result),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= (int'($urandom_range(99)) < stall_pct);
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // offers one transaction after a random gap and returns at the edge that takes it;
  // valid stays high on return so back-to-back transactions need no dead cycle
  task automatic send_item(input op_e op, input logic [ValueW-1:0] value, input rnd_e mode,
                           input logic [ValueW-1:0] ticks, input logic [ValueW-1:0] other);
    while (int'($urandom_range(99)) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    value_in   <= value;
    round_mode <= mode;
    tick_count <= ticks;
    other_code <= other;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // holds the sender off until every awaited result is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // only called with the block drained
  task automatic set_tick(input logic [IncW-1:0] size);
    cfg_we   <= 1'b1;
    cfg_data <= size;
    @(posedge clk);
    cfg_we   <= 1'b0;
    eff_tick = (size == '0) ? longint'(1) : longint'(size);
  endtask

  // codes clustered where rounding gets interesting: ties, exact multiples,
  // neighbors of multiples and the two ends of the range
  function automatic logic [ValueW-1:0] pick_code(input longint tick);
    longint k;
    k = longint'($urandom_range(40)) - 20;
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return 32'(longint'($urandom_range(400)) - 200);
      2:       return 32'(k * tick + tick / 2);
      3:       return 32'(k * tick + longint'($urandom_range(2)) - 1);
      4:       return CodeMax - 32'($urandom_range(int'(2 * tick)));
      default: return CodeMin + 32'($urandom_range(int'(2 * tick)));
    endcase
  endfunction

  function automatic logic [ValueW-1:0] pick_ticks();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($urandom_range(20)) - 32'd10;
      2:       return $urandom_range(1) ? CodeMax : CodeMin;
      default: return 32'($urandom_range(3000)) - 32'd1500;
    endcase
  endfunction

  initial begin
    // tick sizes per random phase: zero, the top of the field above the
    // nominal range, the nominal maximum, odd and even small sizes
    tick_plan = '{20'd0, 20'd1000000, 20'd2, 20'd7, 20'hFFFFF, 20'd3,
                  20'd10, 20'd1, 20'd1, 20'd4, 20'd2, 20'd100};
    tick_plan[7]  = 20'($urandom_range(1000000, 1));
    tick_plan[10] = 20'($urandom_range(64, 2));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 37;
    stall_pct   <= 52;

    // directed, tick size still at its reset value of one
    send_item(OP_CMP, '0, RND_FLOOR, '0, '0);                   // equal against reset code
    send_item(OP_SET, CodeMax, RND_FLOOR, '0, '0);
    send_item(OP_ADD, '0, RND_FLOOR, 32'd1, '0);                // wraps past the top
    send_item(OP_SUB, '0, RND_FLOOR, 32'd1, '0);                // and back past the bottom
    send_item(OP_CMP, '0, RND_FLOOR, '0, CodeMin);              // greater
    send_item(OP_SET, CodeMin, RND_EXACT, '0, '0);
    send_item(OP_CMP, '0, RND_FLOOR, '0, CodeMax);              // less

    // even tick: ties, every rounding mode on both signs, exact hit and miss
    drain();
    set_tick(20'd4);
    send_item(OP_SET, 32'd6, RND_NEAREST_EVEN, '0, '0);         // tie, rounds up to even
    send_item(OP_SET, 32'd10, RND_NEAREST_EVEN, '0, '0);        // tie, rounds down to even
    send_item(OP_SET, -32'sd6, RND_NEAREST_EVEN, '0, '0);
    send_item(OP_SET, 32'd7, RND_CEIL, '0, '0);
    send_item(OP_SET, -32'sd7, RND_CEIL, '0, '0);
    send_item(OP_SET, 32'd7, RND_FLOOR, '0, '0);
    send_item(OP_SET, -32'sd7, RND_FLOOR, '0, '0);
    send_item(OP_SET, 32'd7, RND_EXACT, '0, '0);                // miss, truncates toward zero
    send_item(OP_SET, -32'sd7, RND_EXACT, '0, '0);
    send_item(OP_SET, 32'd12, RND_EXACT, '0, '0);
    send_item(OP_SET, CodeMax, RND_CEIL, '0, '0);               // rounds past the top
    send_item(OP_SET, CodeMin, RND_FLOOR, '0, '0);
    send_item(OP_SET, CodeMin + 32'd1, RND_FLOOR, '0, '0);

    // large tick: rounding below the range, inexact with a huge value,
    // extreme tick counts
    drain();
    set_tick(20'd1000000);
    send_item(OP_SET, CodeMin, RND_FLOOR, '0, '0);              // rounds past the bottom
    send_item(OP_SET, CodeMax, RND_EXACT, '0, '0);
    send_item(OP_ADD, '0, RND_FLOOR, CodeMax, '0);
    send_item(OP_SUB, '0, RND_FLOOR, CodeMin, '0);
    send_item(OP_CMP, '0, RND_FLOOR, '0, $urandom);

    // random phases: receiver idles more, then sender idles more, then no idling
    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain();
      if (phase == 4) begin
        send_gap_pct = 52;
        stall_pct   <= 37;
      end else if (phase == 8) begin
        send_gap_pct = 0;
        stall_pct   <= 0;
      end
      set_tick(tick_plan[phase]);
      for (int i = 0; i < PhaseItems; i++) begin
        // one full stop halfway through every phase
        if (i == PhaseItems / 2) drain();
        send_item(op_e'($urandom_range(3)), pick_code(eff_tick), rnd_e'($urandom_range(3)),
                  pick_ticks(), pick_code(eff_tick));
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (pending != 0) begin
      $display("%0t: %0d awaited results never arrived", $time, pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
